@@ src/rprc_pkg.sv @@
// ----------------------------------------------------------------------------
// rprc_pkg
// Shared types and constants for the request policy range classifier.
// ----------------------------------------------------------------------------
package rprc_pkg;

    // field widths of the input and result words
    localparam int SLOT_W    = 4;
    localparam int START_W   = 31;
    localparam int POLICY_W  = 8;
    localparam int REQ_W     = 32;
    localparam int VERDICT_W = 2;
    localparam int COUNT_W   = 5;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic REG_RANGE_COUNT = 1'b0;
    localparam logic REG_ON_CONNECT  = 1'b1;

    localparam logic [COUNT_W-1:0]  RANGE_COUNT_RESET = 5'd1;
    localparam logic [POLICY_W-1:0] ON_CONNECT_RESET  = 8'd0;

    // item kinds
    localparam logic KIND_LOAD     = 1'b0;
    localparam logic KIND_CLASSIFY = 1'b1;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_CHECK   = 2'd0,
        VERDICT_SPECIAL = 2'd1,
        VERDICT_DIRECT  = 2'd2
    } verdict_t;

endpackage

@@ src/request_policy_range_classifier.sv @@
// ----------------------------------------------------------------------------
// request_policy_range_classifier
// Classifies request numbers against a table of ascending range starts by
// binary search; load words fill the table one slot at a time.
// ----------------------------------------------------------------------------
//
//   channel   handshake            payload
//   -------   ------------------   ---------------------------------------------
//   input     in_valid / in_stall  kind, slot, range_start, policy_byte,
//                                  request_number
//   result    out_valid/out_stall  verdict, element_index, special_code,
//                                  matched_slot, was_connect
//   config    APB (psel..pready)   range_count (0x0), on_connect_policy (0x4)
//
// a load word writes the table ram directly
// a classify word runs a search of S compare steps (at most clog2(n)+1, n the
// searched slot count; none for -1 and below): one ram read per step, its
// compare steering the next read address
// one word is worked on at a time; a finished result sits in the output
// register while the next word is taken; a stalled output holds the block
// only once the next result is ready
// reset clears control and configuration; the table is undefined until loaded
// ----------------------------------------------------------------------------
module request_policy_range_classifier #(
    parameter int TABLE_DEPTH   = 16,
    parameter int SPECIAL_FLOOR = 250
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   kind,
    input  logic [rprc_pkg::SLOT_W-1:0]            slot,
    input  logic [rprc_pkg::START_W-1:0]           range_start,
    input  logic [rprc_pkg::POLICY_W-1:0]          policy_byte,
    input  logic signed [rprc_pkg::REQ_W-1:0]      request_number,

    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [rprc_pkg::VERDICT_W-1:0]         verdict,
    output logic [rprc_pkg::POLICY_W-1:0]          element_index,
    output logic [rprc_pkg::POLICY_W-1:0]          special_code,
    output logic [rprc_pkg::SLOT_W-1:0]            matched_slot,
    output logic                                   was_connect,

    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [rprc_pkg::PADDR_W-1:0]           paddr,
    input  logic [rprc_pkg::PDATA_W-1:0]           pwdata,
    output logic [rprc_pkg::PDATA_W-1:0]           prdata,
    output logic                                   pready
);

    localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW     = $clog2(TABLE_DEPTH + 1);
    localparam int WORD_W = rprc_pkg::START_W + rprc_pkg::POLICY_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [rprc_pkg::COUNT_W-1:0]  range_count_reg;
    logic [rprc_pkg::POLICY_W-1:0] on_connect_reg;
    logic                          cfg_write;
    logic                          cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_count_reg <= rprc_pkg::RANGE_COUNT_RESET;
            on_connect_reg  <= rprc_pkg::ON_CONNECT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rprc_pkg::REG_RANGE_COUNT: range_count_reg <= pwdata[rprc_pkg::COUNT_W-1:0];
                rprc_pkg::REG_ON_CONNECT:  on_connect_reg  <= pwdata[rprc_pkg::POLICY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            rprc_pkg::REG_RANGE_COUNT: prdata = rprc_pkg::PDATA_W'(range_count_reg);
            rprc_pkg::REG_ON_CONNECT:  prdata = rprc_pkg::PDATA_W'(on_connect_reg);
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // control and datapath registers
    // ------------------------------------------------------------------
    state_t                        state_reg;
    logic                          out_valid_reg;
    logic [rprc_pkg::VERDICT_W-1:0] verdict_reg;
    logic [rprc_pkg::POLICY_W-1:0] element_reg;
    logic [rprc_pkg::POLICY_W-1:0] special_reg;
    logic [rprc_pkg::SLOT_W-1:0]   matched_reg;
    logic                          connect_reg;

    logic [rprc_pkg::POLICY_W-1:0] res_byte_reg;
    logic [AW-1:0]                 res_slot_reg;
    logic                          res_connect_reg;
    logic                          res_direct_reg;

    logic [rprc_pkg::START_W-1:0]  number_reg;
    logic [CW-1:0]                 lo_reg, lo_next;
    logic [CW-1:0]                 hi_reg, hi_next;
    logic [AW-1:0]                 mid_reg, mid_next;
    logic [AW-1:0]                 cand_slot_reg, cand_slot_next;
    logic [rprc_pkg::POLICY_W-1:0] cand_byte_reg, cand_byte_next;

    logic                          in_accept;
    logic                          out_free;
    logic                          search_more;
    logic [CW:0]                   mid_sum;
    logic [CW-1:0]                 n_clamped;
    logic [31:0]                   count_ext;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [WORD_W-1:0]             ram_wdata;
    logic [WORD_W-1:0]             ram_rdata;
    logic [rprc_pkg::START_W-1:0]  rd_start;
    logic [rprc_pkg::POLICY_W-1:0] rd_policy;
    logic                          go_left;

    logic [31:0]                   slot_ext;
    logic [31:0]                   res_slot_ext;
    rprc_pkg::verdict_t            res_verdict;
    logic [rprc_pkg::POLICY_W-1:0] res_element;
    logic [rprc_pkg::POLICY_W-1:0] res_special;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // table write from load words
    assign slot_ext  = 32'(slot);
    assign ram_we    = in_accept && (kind == rprc_pkg::KIND_LOAD) && (slot_ext < TABLE_DEPTH);
    assign ram_waddr = AW'(slot);
    assign ram_wdata = {range_start, policy_byte};

    assign rd_start  = ram_rdata[WORD_W-1:rprc_pkg::POLICY_W];
    assign rd_policy = ram_rdata[rprc_pkg::POLICY_W-1:0];
    assign go_left   = rd_start > number_reg;

    // searched slot count, zero taken as one, saturated at the depth
    assign count_ext = 32'(range_count_reg);
    always_comb
    begin
        priority if (count_ext == 32'd0)
            n_clamped = CW'(1);
        else if (count_ext > TABLE_DEPTH)
            n_clamped = CW'(TABLE_DEPTH);
        else
            n_clamped = CW'(count_ext);
    end

    // idle sets the range to all searched slots; one search step: the compare of
    // the word read last cycle picks the next half, and its middle is read right away
    always_comb
    begin
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        cand_slot_next = cand_slot_reg;
        cand_byte_next = cand_byte_reg;
        if (state_reg == ST_IDLE)
        begin
            lo_next        = '0;
            hi_next        = n_clamped;
            cand_slot_next = '0;
            cand_byte_next = '0;
        end
        else if (state_reg == ST_SEARCH)
        begin
            if (go_left)
            begin
                hi_next = CW'(mid_reg);
                // nothing below slot 0 holds the number: slot 0 is used
                if (mid_reg == '0)
                begin
                    cand_slot_next = '0;
                    cand_byte_next = rd_policy;
                end
            end
            else
            begin
                lo_next        = CW'(mid_reg) + CW'(1);
                cand_slot_next = mid_reg;
                cand_byte_next = rd_policy;
            end
        end
        mid_sum     = (CW + 1)'(lo_next) + (CW + 1)'(hi_next);
        mid_next    = AW'(mid_sum >> 1);
        search_more = hi_next > lo_next;
    end

    rprc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (mid_next),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        cand_slot_reg <= cand_slot_next;
        cand_byte_reg <= cand_byte_next;
    end

    // policy byte to verdict
    assign res_slot_ext = 32'(res_slot_reg);
    always_comb
    begin
        res_element = '0;
        res_special = '0;
        priority if (res_direct_reg)
            res_verdict = rprc_pkg::VERDICT_DIRECT;
        else if (res_byte_reg >= rprc_pkg::POLICY_W'(SPECIAL_FLOOR))
        begin
            res_verdict = rprc_pkg::VERDICT_SPECIAL;
            res_special = res_byte_reg;
        end
        else
        begin
            res_verdict = rprc_pkg::VERDICT_CHECK;
            res_element = res_byte_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            verdict_reg     <= '0;
            element_reg     <= '0;
            special_reg     <= '0;
            matched_reg     <= '0;
            connect_reg     <= 1'b0;
            res_byte_reg    <= '0;
            res_slot_reg    <= '0;
            res_connect_reg <= 1'b0;
            res_direct_reg  <= 1'b0;
            number_reg      <= '0;
        end
        else
        begin
            // a finishing word reloads the output register below
            if (out_valid_reg && !out_stall && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept && (kind == rprc_pkg::KIND_CLASSIFY))
                    begin
                        res_slot_reg    <= '0;
                        res_connect_reg <= 1'b0;
                        res_direct_reg  <= 1'b0;
                        res_byte_reg    <= '0;
                        if (!request_number[rprc_pkg::REQ_W-1])
                        begin
                            number_reg <= request_number[rprc_pkg::START_W-1:0];
                            state_reg  <= ST_SEARCH;
                        end
                        else if (&request_number)
                        begin
                            // connect request
                            res_byte_reg    <= on_connect_reg;
                            res_connect_reg <= 1'b1;
                            state_reg       <= ST_FINISH;
                        end
                        else
                        begin
                            res_direct_reg <= 1'b1;
                            state_reg      <= ST_FINISH;
                        end
                    end
                end
                ST_SEARCH:
                begin
                    if (!search_more)
                    begin
                        res_byte_reg <= cand_byte_next;
                        res_slot_reg <= cand_slot_next;
                        state_reg    <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        verdict_reg   <= res_verdict;
                        element_reg   <= res_element;
                        special_reg   <= res_special;
                        matched_reg   <= res_slot_ext[rprc_pkg::SLOT_W-1:0];
                        connect_reg   <= res_connect_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign verdict       = verdict_reg;
    assign element_index = element_reg;
    assign special_code  = special_reg;
    assign matched_slot  = matched_reg;
    assign was_connect   = connect_reg;

endmodule

@@ src/rprc_ram.sv @@
// ----------------------------------------------------------------------------
// rprc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rprc_ram #(
    parameter int WIDTH = 39,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
